@@ rtl/core/lcrd_pkg.sv @@
// shared constants, types and reset table for the load cell register device
// no dependencies
package lcrd_pkg;

   localparam int REG_BYTES = 256;
   localparam int ADDR_W    = $clog2(REG_BYTES);
   localparam int MAX_BURST = 64;
   localparam int NUM_SENSORS = 4;

   localparam logic [6:0] DEV_ADDR_RESET = 7'd82;

   localparam logic [1:0] OP_READ   = 2'd0;
   localparam logic [1:0] OP_WRITE  = 2'd1;
   localparam logic [1:0] OP_UPDATE = 2'd2;

   localparam logic [7:0] CAL_BASE = 8'h20;
   localparam logic [7:0] ID_ADDR0 = 8'hFE;
   localparam logic [7:0] ID_ADDR1 = 8'hFF;
   localparam logic [7:0] ID_BYTE0 = 8'h04;
   localparam logic [7:0] ID_BYTE1 = 8'h02;

   // fixed bytes written by a sensor update
   localparam logic [7:0] UPD_BYTE8   = 8'h19;
   localparam logic [7:0] UPD_BYTE9   = 8'h00;
   localparam logic [7:0] UPD_BYTE10  = 8'h69;
   localparam logic [7:0] UPD_EXT_A0  = 8'h60;
   localparam logic [7:0] UPD_EXT_A1  = 8'h61;
   localparam logic [7:0] UPD_EXT_D0  = 8'h19;
   localparam logic [7:0] UPD_EXT_D1  = 8'h01;
   localparam logic [3:0] UPD_LAST_STEP = 4'd12;

   localparam logic [7:0] CAL_BLOCK [32] = '{
      8'h01, 8'h69, 8'h00, 8'h00,
      8'h07, 8'hBC, 8'h11, 8'h8B, 8'h06, 8'hBA, 8'h46, 8'h52,
      8'h0E, 8'h6E, 8'h18, 8'h79, 8'h0D, 8'h5D, 8'h4D, 8'h4C,
      8'h15, 8'h2E, 8'h1F, 8'h71, 8'h14, 8'h07, 8'h54, 8'h51,
      8'hA9, 8'h06, 8'hB4, 8'hF0
   };

   localparam logic [15:0] CAL_POINTS [4][3] = '{
      '{16'h07BC, 16'h0E6E, 16'h152E},
      '{16'h118B, 16'h1879, 16'h1F71},
      '{16'h06BA, 16'h0D5D, 16'h1407},
      '{16'h4652, 16'h4D4C, 16'h5451}
   };

   typedef struct packed {
      logic       valid;
      logic [1:0] idx;
   } conv_tag_type;

   function automatic logic [7:0] init_byte(input logic [ADDR_W-1:0] a);
      logic [7:0] b;
      b = 8'h00;
      if (a[7:5] == CAL_BASE[7:5]) begin
         b = CAL_BLOCK[a[4:0]];
      end else if (a == ID_ADDR0) begin
         b = ID_BYTE0;
      end else if (a == ID_ADDR1) begin
         b = ID_BYTE1;
      end
      return b;
   endfunction

endpackage

@@ rtl/core/load_cell_register_device_core.sv @@
// top level: command decode, sequencer and register file of the load cell device
// depends on lcrd_pkg, lcrd_ram, lcrd_conv
//
// Transactions are taken while busy is low; busy is high from reset through a
// pass that loads the register file with its reset image, and while a
// transaction is worked on. A read burst of n bytes gives one result a cycle
// (one memory read per cycle sets that pace); a write, a rejected access or an
// empty read gives a single result; a sensor update runs four sensors through a
// three stage conversion, then thirteen byte writes through the single memory
// write port. Each result is shown for one cycle on the rsp_ ports with
// rsp_valid high; the receiver cannot stall.
module load_cell_register_device_core import lcrd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_op,
   input  logic [6:0]  req_bus_address,
   input  logic [7:0]  req_start_offset,
   input  logic [6:0]  req_burst_length,
   input  logic [5:0]  req_byte_index,
   input  logic [7:0]  req_write_byte,
   input  logic [7:0]  req_weight_top_right,
   input  logic [7:0]  req_weight_bottom_right,
   input  logic [7:0]  req_weight_top_left,
   input  logic [7:0]  req_weight_bottom_left,
   input  logic        csr_write_enable,
   input  logic [6:0]  csr_write_data,
   output logic        rsp_valid,
   output logic [7:0]  rsp_read_byte,
   output logic        rsp_accepted,
   output logic [6:0]  rsp_byte_count,
   output logic        rsp_last
);

   localparam logic [2:0] ST_INIT   = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_DECODE = 3'd2;
   localparam logic [2:0] ST_READ   = 3'd3;
   localparam logic [2:0] ST_CONV   = 3'd4;
   localparam logic [2:0] ST_UPDW   = 3'd5;

   logic [2:0]  state_ff, state_in;
   logic [7:0]  cnt_ff,   cnt_in;
   logic [6:0]  dev_addr_ff;
   logic [1:0]  op_ff;
   logic [6:0]  bus_addr_ff;
   logic [7:0]  start_ff;
   logic [6:0]  count_ff;
   logic [5:0]  index_ff;
   logic [7:0]  data_ff;
   logic [7:0]  weight_ff [NUM_SENSORS];
   logic [15:0] raw_ff    [NUM_SENSORS];

   logic               accept;
   logic               access_ok;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [7:0]         wr_data;
   logic [ADDR_W-1:0]  rd_addr;
   logic [7:0]         rd_data;
   conv_tag_type       conv_in_tag;
   conv_tag_type       conv_out_tag;
   logic [15:0]        conv_raw;
   logic [15:0]        upd_raw;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   assign access_ok = (bus_addr_ff == dev_addr_ff)
                   && ((9'(start_ff) + 9'(count_ff)) <= 9'(REG_BYTES))
                   && (count_ff <= 7'(MAX_BURST));

   lcrd_ram #(
      .WIDTH (8),
      .DEPTH (REG_BYTES)
   ) u_regfile (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign conv_in_tag.valid = (state_ff == ST_CONV) && !cnt_ff[2];
   assign conv_in_tag.idx   = cnt_ff[1:0];

   lcrd_conv u_conv (
      .clock   (clock),
      .reset   (reset),
      .in_tag  (conv_in_tag),
      .weight  (weight_ff[cnt_ff[1:0]]),
      .out_tag (conv_out_tag),
      .raw     (conv_raw)
   );

   assign rd_addr = (state_ff == ST_READ) ? start_ff + 8'(cnt_ff[5:0]) + 8'd1 : start_ff;
   assign upd_raw = raw_ff[cnt_ff[2:1]];

   // memory write source
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cnt_ff;
      wr_data = 8'h00;
      unique case (state_ff)
         ST_INIT: begin
            wr_en   = 1'b1;
            wr_data = init_byte(cnt_ff);
         end
         ST_DECODE: begin
            wr_en   = (op_ff == OP_WRITE) && access_ok && (7'(index_ff) < count_ff);
            wr_addr = start_ff + 8'(index_ff);
            wr_data = data_ff;
         end
         ST_UPDW: begin
            wr_en = 1'b1;
            case (cnt_ff[3:0])
               4'd8:    wr_data = UPD_BYTE8;
               4'd9:    wr_data = UPD_BYTE9;
               4'd10:   wr_data = UPD_BYTE10;
               4'd11: begin
                  wr_addr = UPD_EXT_A0;
                  wr_data = UPD_EXT_D0;
               end
               4'd12: begin
                  wr_addr = UPD_EXT_A1;
                  wr_data = UPD_EXT_D1;
               end
               default: wr_data = cnt_ff[0] ? upd_raw[7:0] : upd_raw[15:8];
            endcase
         end
         default: wr_en = 1'b0;
      endcase
   end

   // sequencer and result generation
   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      rsp_valid      = 1'b0;
      rsp_read_byte  = 8'h00;
      rsp_accepted   = 1'b0;
      rsp_byte_count = 7'd0;
      rsp_last       = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            cnt_in = cnt_ff + 8'd1;
            if (cnt_ff == 8'(REG_BYTES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            cnt_in = 8'd0;
            if (accept) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cnt_in = 8'd0;
            if (op_ff == OP_UPDATE) begin
               state_in = ST_CONV;
            end else if (op_ff == OP_READ && access_ok && count_ff != 7'd0) begin
               state_in = ST_READ;
            end else begin
               state_in  = ST_IDLE;
               rsp_valid = 1'b1;
               rsp_last  = 1'b1;
               if (op_ff == OP_READ && access_ok) begin
                  rsp_accepted = 1'b1;
               end else if (op_ff == OP_WRITE && access_ok
                            && (7'(index_ff) < count_ff)) begin
                  rsp_accepted   = 1'b1;
                  rsp_byte_count = count_ff;
               end
            end
         end
         ST_READ: begin
            rsp_valid      = 1'b1;
            rsp_read_byte  = rd_data;
            rsp_accepted   = 1'b1;
            rsp_byte_count = count_ff;
            rsp_last       = (7'(cnt_ff[5:0]) == count_ff - 7'd1);
            cnt_in         = cnt_ff + 8'd1;
            if (rsp_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_CONV: begin
            if (!cnt_ff[2]) begin
               cnt_in = cnt_ff + 8'd1;
            end
            if (conv_out_tag.valid && conv_out_tag.idx == 2'(NUM_SENSORS - 1)) begin
               state_in = ST_UPDW;
               cnt_in   = 8'd0;
            end
         end
         ST_UPDW: begin
            cnt_in = cnt_ff + 8'd1;
            if (cnt_ff[3:0] == UPD_LAST_STEP) begin
               state_in     = ST_IDLE;
               rsp_valid    = 1'b1;
               rsp_accepted = 1'b1;
               rsp_last     = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_INIT;
         cnt_ff      <= 8'd0;
         dev_addr_ff <= DEV_ADDR_RESET;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (csr_write_enable) begin
            dev_addr_ff <= csr_write_data;
         end
      end
      if (accept) begin
         op_ff        <= req_op;
         bus_addr_ff  <= req_bus_address;
         start_ff     <= req_start_offset;
         count_ff     <= req_burst_length;
         index_ff     <= req_byte_index;
         data_ff      <= req_write_byte;
         weight_ff[0] <= req_weight_top_right;
         weight_ff[1] <= req_weight_bottom_right;
         weight_ff[2] <= req_weight_top_left;
         weight_ff[3] <= req_weight_bottom_left;
      end
      if (conv_out_tag.valid) begin
         raw_ff[conv_out_tag.idx] <= conv_raw;
      end
   end

endmodule

@@ rtl/core/lcrd_ram.sv @@
// generic single write port ram with registered read
// no dependencies
module lcrd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/lcrd_conv.sv @@
// three stage weight to raw conversion, two segment interpolation
// depends on lcrd_pkg
module lcrd_conv import lcrd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  conv_tag_type in_tag,
   input  logic [7:0]   weight,
   output conv_tag_type out_tag,
   output logic [15:0]  raw
);

   conv_tag_type tag1_ff, tag2_ff, tag3_ff;
   logic [23:0]  prod_ff,  prod_in;
   logic [15:0]  base1_ff, base1_in, base2_ff;
   logic [24:0]  y_ff;
   logic [16:0]  q0_ff;
   logic [15:0]  raw_ff,   raw_in;

   logic [7:0]  mult;
   logic [15:0] top;
   logic [15:0] diff;
   logic [24:0] y_in;
   logic [33:0] recip;
   logic [24:0] qm;
   logic [24:0] rem;
   logic [16:0] q;
   logic [17:0] sum;

   // stage 1: segment select and multiply
   always_comb begin
      if (weight[7]) begin
         mult     = 8'({weight, 1'b0} - 9'd255);
         base1_in = CAL_POINTS[in_tag.idx][1];
         top      = CAL_POINTS[in_tag.idx][2];
      end else begin
         mult     = {weight[6:0], 1'b0};
         base1_in = CAL_POINTS[in_tag.idx][0];
         top      = CAL_POINTS[in_tag.idx][1];
      end
      diff    = top - base1_in;
      prod_in = 24'(mult) * 24'(diff);
   end

   // stage 2: rounding offset and reciprocal estimate of divide by 255
   always_comb begin
      y_in  = 25'(prod_ff) + 25'd127;
      recip = 34'(y_in) + (34'(y_in) << 8);
   end

   // stage 3: one step correction, add base, saturate
   always_comb begin
      qm  = (25'(q0_ff) << 8) - 25'(q0_ff);
      rem = y_ff - qm;
      q   = (rem >= 25'd255) ? q0_ff + 17'd1 : q0_ff;
      sum = 18'(base2_ff) + 18'(q);
      raw_in = (sum > 18'h0FFFF) ? 16'hFFFF : sum[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
      end else begin
         tag1_ff <= in_tag;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
      end
      prod_ff  <= prod_in;
      base1_ff <= base1_in;
      y_ff     <= y_in;
      q0_ff    <= recip[32:16];
      base2_ff <= base1_ff;
      raw_ff   <= raw_in;
   end

   assign out_tag = tag3_ff;
   assign raw     = raw_ff;

endmodule

@@ sim/tb.sv @@
// testbench for load_cell_register_device_core: directed table, then random accesses
// checked against a behavioral model of the register file; depends on lcrd_pkg and the rtl
`timescale 1ns / 100ps
module tb;
   import lcrd_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 40;
   localparam int PHASE_ITEMS    = 59;

   typedef struct packed {
      logic [1:0]  op;
      logic [6:0]  bus_addr;
      logic [7:0]  start_off;
      logic [6:0]  length;
      logic [5:0]  index;
      logic [7:0]  data;
      logic [31:0] loads;   // top right, bottom right, top left, bottom left
   } access_t;

   typedef struct packed {
      logic [7:0] rd;
      logic       acc;
      logic [6:0] cnt;
      logic       last;
   } xfer_t;

   typedef struct packed {
      access_t acc;
      logic    typed;
      xfer_t   want;
   } row_t;

   localparam xfer_t NOT_TAKEN   = '{8'h00, 1'b0, 7'd0, 1'b1};
   localparam xfer_t TAKEN_EMPTY = '{8'h00, 1'b1, 7'd0, 1'b1};
   localparam xfer_t UNTYPED     = '0;

   row_t directed_rows [25] = '{
      '{'{OP_READ,   DEV_ADDR_RESET, 8'hFF, 7'd1,   6'd0,  8'h00, 32'h0}, 1'b1,
        '{8'h02, 1'b1, 7'd1, 1'b1}},
      '{'{OP_READ,   DEV_ADDR_RESET, 8'hFE, 7'd1,   6'd0,  8'h00, 32'h0}, 1'b1,
        '{8'h04, 1'b1, 7'd1, 1'b1}},
      '{'{OP_READ,   DEV_ADDR_RESET, 8'h20, 7'd32,  6'd0,  8'h00, 32'h0}, 1'b0, UNTYPED},
      '{'{OP_READ,   DEV_ADDR_RESET, 8'hC0, 7'd64,  6'd0,  8'h00, 32'h0}, 1'b0, UNTYPED},
      '{'{OP_READ,   DEV_ADDR_RESET, 8'hC1, 7'd64,  6'd0,  8'h00, 32'h0}, 1'b1, NOT_TAKEN},
      '{'{OP_READ,   DEV_ADDR_RESET, 8'h00, 7'd65,  6'd0,  8'h00, 32'h0}, 1'b1, NOT_TAKEN},
      '{'{OP_READ,   DEV_ADDR_RESET, 8'h00, 7'd127, 6'd0,  8'h00, 32'h0}, 1'b1, NOT_TAKEN},
      '{'{OP_READ,   7'd81,          8'h00, 7'd1,   6'd0,  8'h00, 32'h0}, 1'b1, NOT_TAKEN},
      '{'{OP_READ,   DEV_ADDR_RESET, 8'hFF, 7'd0,   6'd0,  8'h00, 32'h0}, 1'b1, TAKEN_EMPTY},
      '{'{OP_WRITE,  DEV_ADDR_RESET, 8'h10, 7'd0,   6'd0,  8'h11, 32'h0}, 1'b1, NOT_TAKEN},
      '{'{OP_WRITE,  DEV_ADDR_RESET, 8'h10, 7'd4,   6'd3,  8'hA5, 32'h0}, 1'b1,
        '{8'h00, 1'b1, 7'd4, 1'b1}},
      '{'{OP_WRITE,  DEV_ADDR_RESET, 8'h10, 7'd4,   6'd4,  8'h3C, 32'h0}, 1'b1, NOT_TAKEN},
      '{'{OP_WRITE,  DEV_ADDR_RESET, 8'hC0, 7'd64,  6'd63, 8'hFF, 32'h0}, 1'b1,
        '{8'h00, 1'b1, 7'd64, 1'b1}},
      '{'{OP_WRITE,  7'd0,           8'hC0, 7'd64,  6'd0,  8'h77, 32'h0}, 1'b1, NOT_TAKEN},
      '{'{OP_WRITE,  DEV_ADDR_RESET, 8'hFF, 7'd1,   6'd0,  8'h5A, 32'h0}, 1'b1,
        '{8'h00, 1'b1, 7'd1, 1'b1}},
      '{'{OP_WRITE,  DEV_ADDR_RESET, 8'hFF, 7'd2,   6'd0,  8'h66, 32'h0}, 1'b1, NOT_TAKEN},
      '{'{OP_READ,   DEV_ADDR_RESET, 8'hC0, 7'd64,  6'd0,  8'h00, 32'h0}, 1'b0, UNTYPED},
      '{'{OP_READ,   DEV_ADDR_RESET, 8'h00, 7'd16,  6'd0,  8'h00, 32'h0}, 1'b0, UNTYPED},
      '{'{OP_UPDATE, 7'd0,           8'h00, 7'd0,   6'd0,  8'h00, 32'h0}, 1'b1, TAKEN_EMPTY},
      '{'{OP_READ,   DEV_ADDR_RESET, 8'h00, 7'd11,  6'd0,  8'h00, 32'h0}, 1'b0, UNTYPED},
      '{'{OP_UPDATE, DEV_ADDR_RESET, 8'h00, 7'd0,   6'd0,  8'h00, 32'hFF7F8001}, 1'b1,
        TAKEN_EMPTY},
      '{'{OP_READ,   DEV_ADDR_RESET, 8'h00, 7'd11,  6'd0,  8'h00, 32'h0}, 1'b0, UNTYPED},
      '{'{OP_READ,   DEV_ADDR_RESET, 8'h60, 7'd2,   6'd0,  8'h00, 32'h0}, 1'b0, UNTYPED},
      '{'{OP_UNUSED, 7'h7F,          8'hFF, 7'h7F,  6'h3F, 8'hFF, 32'hFFFFFFFF}, 1'b1,
        NOT_TAKEN},
      '{'{OP_UNUSED, DEV_ADDR_RESET, 8'h00, 7'd1,   6'd0,  8'h00, 32'h0}, 1'b1, NOT_TAKEN}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_op = '0;
   logic [6:0]  req_bus_address = '0;
   logic [7:0]  req_start_offset = '0;
   logic [6:0]  req_burst_length = '0;
   logic [5:0]  req_byte_index = '0;
   logic [7:0]  req_write_byte = '0;
   logic [7:0]  req_weight_top_right = '0;
   logic [7:0]  req_weight_bottom_right = '0;
   logic [7:0]  req_weight_top_left = '0;
   logic [7:0]  req_weight_bottom_left = '0;
   logic        csr_write_enable = 1'b0;
   logic [6:0]  csr_write_data = '0;
   logic        rsp_valid;
   logic [7:0]  rsp_read_byte;
   logic        rsp_accepted;
   logic [6:0]  rsp_byte_count;
   logic        rsp_last;

   logic [7:0] shadow_regs [REG_BYTES];
   logic [6:0] shadow_dev_addr;
   xfer_t      expected_q [$];
   xfer_t      model_out [$];
   int         errors = 0;
   int         idle_cycles = 0;
   int         issued = 0;

   load_cell_register_device_core dut (
      .clock                   (clock),
      .reset                   (reset),
      .start                   (start),
      .busy                    (busy),
      .req_op                  (req_op),
      .req_bus_address         (req_bus_address),
      .req_start_offset        (req_start_offset),
      .req_burst_length        (req_burst_length),
      .req_byte_index          (req_byte_index),
      .req_write_byte          (req_write_byte),
      .req_weight_top_right    (req_weight_top_right),
      .req_weight_bottom_right (req_weight_bottom_right),
      .req_weight_top_left     (req_weight_top_left),
      .req_weight_bottom_left  (req_weight_bottom_left),
      .csr_write_enable        (csr_write_enable),
      .csr_write_data          (csr_write_data),
      .rsp_valid               (rsp_valid),
      .rsp_read_byte           (rsp_read_byte),
      .rsp_accepted            (rsp_accepted),
      .rsp_byte_count          (rsp_byte_count),
      .rsp_last                (rsp_last)
   );

   always #1 clock = ~clock;

   task automatic log_mismatch(input string msg);
      errors++;
      $display("%0t mismatch: %s", $time, msg);
   endtask

   // two-segment interpolation over the sensor's three calibration points
   function automatic logic [15:0] load_to_raw(input int sensor, input logic [7:0] w);
      int c0, c1, c2, wi, base, num, q, raw;
      c0 = int'(CAL_POINTS[sensor][0]);
      c1 = int'(CAL_POINTS[sensor][1]);
      c2 = int'(CAL_POINTS[sensor][2]);
      wi = int'(w);
      if (wi <= 127) begin
         base = c0;
         num  = 2 * wi * (c1 - c0);
      end else begin
         base = c1;
         num  = (2 * wi - 255) * (c2 - c1);
      end
      q = (num >= 0) ? (2 * num + 255) / 510 : -((255 - 2 * num) / 510);
      raw = base + q;
      if (raw < 0) begin
         raw = 0;
      end else if (raw > 65535) begin
         raw = 65535;
      end
      return raw[15:0];
   endfunction

   task automatic model_access(input access_t a);
      logic       ok;
      logic [15:0] raw;
      model_out.delete();
      ok = (a.bus_addr == shadow_dev_addr) &&
           (int'(a.start_off) + int'(a.length) <= REG_BYTES) && (a.length <= MAX_BURST);
      case (a.op)
         OP_UPDATE: begin
            for (int i = 0; i < NUM_SENSORS; i++) begin
               raw = load_to_raw(i, a.loads[31 - 8 * i -: 8]);
               shadow_regs[2 * i]     = raw[15:8];
               shadow_regs[2 * i + 1] = raw[7:0];
            end
            shadow_regs[8]          = UPD_BYTE8;
            shadow_regs[9]          = UPD_BYTE9;
            shadow_regs[10]         = UPD_BYTE10;
            shadow_regs[UPD_EXT_A0] = UPD_EXT_D0;
            shadow_regs[UPD_EXT_A1] = UPD_EXT_D1;
            model_out.push_back(TAKEN_EMPTY);
         end
         OP_READ: begin
            if (!ok) begin
               model_out.push_back(NOT_TAKEN);
            end else if (a.length == 0) begin
               model_out.push_back(TAKEN_EMPTY);
            end else begin
               for (int k = 0; k < int'(a.length); k++) begin
                  model_out.push_back(xfer_t'{shadow_regs[8'(int'(a.start_off) + k)], 1'b1,
                                              a.length, k == int'(a.length) - 1});
               end
            end
         end
         OP_WRITE: begin
            if (!ok || a.index >= a.length) begin
               model_out.push_back(NOT_TAKEN);
            end else begin
               shadow_regs[8'(a.start_off + a.index)] = a.data;
               model_out.push_back(xfer_t'{8'h00, 1'b1, a.length, 1'b1});
            end
         end
         default: begin
            model_out.push_back(NOT_TAKEN);
         end
      endcase
   endtask

   task automatic issue(input access_t a, input logic typed, input xfer_t want);
      int gap, r;
      @(negedge clock);
      start                   = 1'b1;
      req_op                  = a.op;
      req_bus_address         = a.bus_addr;
      req_start_offset        = a.start_off;
      req_burst_length        = a.length;
      req_byte_index          = a.index;
      req_write_byte          = a.data;
      req_weight_top_right    = a.loads[31:24];
      req_weight_bottom_right = a.loads[23:16];
      req_weight_top_left     = a.loads[15:8];
      req_weight_bottom_left  = a.loads[7:0];
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      model_access(a);
      if (typed) begin
         expected_q.push_back(want);
      end else begin
         foreach (model_out[k]) expected_q.push_back(model_out[k]);
      end
      issued++;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         gap = 0;
      end else if (r < 90) begin
         gap = $urandom_range(1, 3);
      end else begin
         gap = $urandom_range(8, 40);
      end
      if (gap > 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      while (expected_q.size() != 0 || busy !== 1'b0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_config(input logic [6:0] value);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data   = value;
      @(posedge clock);
      shadow_dev_addr = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // mostly well formed bursts, some wrong addresses, overruns and stray indexes
   task automatic random_access();
      access_t a;
      int      r, len, nwr;
      a = '0;
      r = $urandom_range(0, 19);
      if (r < 12) begin
         len = $urandom_range(1, 8);
      end else if (r < 16) begin
         len = $urandom_range(9, 64);
      end else if (r < 18) begin
         len = 0;
      end else begin
         len = $urandom_range(65, 127);
      end
      a.length   = 7'(len);
      a.bus_addr = ($urandom_range(0, 9) != 0) ? shadow_dev_addr : 7'($urandom_range(0, 127));
      if (len <= MAX_BURST && $urandom_range(0, 7) != 0) begin
         a.start_off = 8'($urandom_range(0, (len == 0) ? 255 : REG_BYTES - len));
      end else begin
         a.start_off = 8'($urandom);
      end
      a.index = 6'($urandom);
      a.data  = 8'($urandom);
      a.loads = $urandom;
      r = $urandom_range(0, 99);
      if (r < 40) begin
         a.op = OP_READ;
         issue(a, 1'b0, UNTYPED);
      end else if (r < 75) begin
         a.op = OP_WRITE;
         nwr = (len < 6) ? len : 6;
         if (nwr == 0) begin
            nwr = 1;
         end
         for (int k = 0; k < nwr; k++) begin
            a.index = ($urandom_range(0, 7) != 0) ? 6'(k) : 6'($urandom);
            a.data  = 8'($urandom);
            issue(a, 1'b0, UNTYPED);
         end
         if ($urandom_range(0, 1) == 1) begin
            a.op = OP_READ;
            issue(a, 1'b0, UNTYPED);
         end
      end else if (r < 92) begin
         a.op = OP_UPDATE;
         issue(a, 1'b0, UNTYPED);
         if ($urandom_range(0, 1) == 1) begin
            a.op        = OP_READ;
            a.bus_addr  = shadow_dev_addr;
            a.start_off = 8'h00;
            a.length    = 7'd11;
            issue(a, 1'b0, UNTYPED);
         end
      end else begin
         a.op = OP_UNUSED;
         issue(a, 1'b0, UNTYPED);
      end
   endtask

   task automatic random_phase(input logic [6:0] addr);
      int target;
      target = issued + PHASE_ITEMS;
      drain();
      write_config(addr);
      while (issued < target) random_access();
   endtask

   always @(posedge clock) begin
      xfer_t got, want;
      if (!reset && rsp_valid === 1'b1) begin
         got = '{rsp_read_byte, rsp_accepted, rsp_byte_count, rsp_last};
         if (expected_q.size() == 0) begin
            log_mismatch($sformatf("unexpected transaction rd %h acc %b cnt %0d last %b",
                                   got.rd, got.acc, got.cnt, got.last));
         end else begin
            want = expected_q.pop_front();
            if (got.rd !== want.rd || got.acc !== want.acc || got.cnt !== want.cnt ||
                got.last !== want.last) begin
               log_mismatch($sformatf("rd %h acc %b cnt %0d last %b, want %h %b %0d %b",
                                      got.rd, got.acc, got.cnt, got.last,
                                      want.rd, want.acc, want.cnt, want.last));
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((start && busy === 1'b0) || rsp_valid === 1'b1) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      foreach (shadow_regs[i]) shadow_regs[i] = 8'h00;
      for (int i = 0; i < 32; i++) shadow_regs[CAL_BASE + i] = CAL_BLOCK[i];
      shadow_regs[ID_ADDR0] = ID_BYTE0;
      shadow_regs[ID_ADDR1] = ID_BYTE1;
      shadow_dev_addr = DEV_ADDR_RESET;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      // wait out the register file load after reset
      while (busy !== 1'b0) @(posedge clock);
      write_config(DEV_ADDR_RESET);
      foreach (directed_rows[i]) begin
         issue(directed_rows[i].acc, directed_rows[i].typed, directed_rows[i].want);
      end
      random_phase(7'd0);
      random_phase(7'd127);
      random_phase(7'($urandom));
      random_phase(DEV_ADDR_RESET);
      random_phase(7'($urandom));
      drain();
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
